/* rtl/core/vrbd_pkg.sv */
`default_nettype none
package vrbd_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LEN_W       = 16;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [LEN_W-1:0] DESC_LEN = LEN_W'(4);

  localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RESET = 16'h8000;
  localparam logic [BYTE_W-1:0] SUB_CHAR          = 8'h1A;

  localparam logic [CFG_IDX_W-1:0] REG_TRANSLATE_MODE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BLOCK_PAYLOAD = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_BYTE       = 2'd0,
    KIND_EMPTY      = 2'd1,
    KIND_BLOCK_BAD  = 2'd2,
    KIND_RECORD_BAD = 2'd3
  } kind_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE = 2'd0,
    MODE_037  = 2'd1,
    MODE_1047 = 2'd2,
    MODE_RAW3 = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    PH_BDW0 = 4'd0,
    PH_BDW1 = 4'd1,
    PH_BDW2 = 4'd2,
    PH_BDW3 = 4'd3,
    PH_RDW0 = 4'd4,
    PH_RDW1 = 4'd5,
    PH_RDW2 = 4'd6,
    PH_RDW3 = 4'd7,
    PH_DATA = 4'd8,
    PH_SKIP = 4'd9,
    PH_DEAD = 4'd10
  } phase_t;

  // One classified word handed from the parser to the output side.
  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    logic              last;
  } item_t;

  // Queue status seen by the parser and the output side.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // EBCDIC to ASCII for code pages 037 and 1047; they differ in a few places.
  function automatic logic [BYTE_W-1:0] ebcdic_to_ascii(input logic [BYTE_W-1:0] b,
                                                        input logic is_1047);
    logic [BYTE_W-1:0] r;
    r = SUB_CHAR;
    case (b) inside
      [8'h00:8'h03], [8'h0B:8'h13], [8'h18:8'h19], [8'h1C:8'h1F]: r = b;
      8'h05: r = 8'h09;
      8'h07: r = 8'h7F;
      8'h15: r = is_1047 ? 8'h0A : SUB_CHAR;
      8'h16: r = 8'h08;
      8'h25: r = 8'h0A;
      8'h26: r = 8'h17;
      8'h27: r = 8'h1B;
      8'h2D: r = 8'h05;
      8'h2E: r = 8'h06;
      8'h2F: r = 8'h07;
      8'h32: r = 8'h16;
      8'h37: r = 8'h04;
      8'h3C: r = 8'h14;
      8'h3D: r = 8'h15;
      8'h40: r = 8'h20;
      8'h4A: r = is_1047 ? 8'hA2 : SUB_CHAR;
      8'h4B: r = 8'h2E;
      8'h4C: r = 8'h3C;
      8'h4D: r = 8'h28;
      8'h4E: r = 8'h2B;
      8'h4F: r = 8'h7C;
      8'h50: r = 8'h26;
      8'h5A: r = 8'h21;
      8'h5B: r = 8'h24;
      8'h5C: r = 8'h2A;
      8'h5D: r = 8'h29;
      8'h5E: r = 8'h3B;
      8'h5F: r = is_1047 ? 8'h5E : 8'hAC;
      8'h60: r = 8'h2D;
      8'h61: r = 8'h2F;
      8'h6A: r = is_1047 ? 8'hA6 : SUB_CHAR;
      8'h6B: r = 8'h2C;
      8'h6C: r = 8'h25;
      8'h6D: r = 8'h5F;
      8'h6E: r = 8'h3E;
      8'h6F: r = 8'h3F;
      8'h79: r = 8'h60;
      8'h7A: r = 8'h3A;
      8'h7B: r = 8'h23;
      8'h7C: r = 8'h40;
      8'h7D: r = 8'h27;
      8'h7E: r = 8'h3D;
      8'h7F: r = 8'h22;
      [8'h81:8'h89]: r = b - 8'h20;
      [8'h91:8'h99]: r = b - 8'h27;
      8'hA1: r = 8'h7E;
      [8'hA2:8'hA9]: r = b - 8'h2F;
      8'hAD: r = is_1047 ? 8'h5B : SUB_CHAR;
      8'hB0: r = is_1047 ? SUB_CHAR : 8'h5E;
      8'hBA: r = is_1047 ? SUB_CHAR : 8'h5B;
      8'hBB: r = is_1047 ? SUB_CHAR : 8'h5D;
      8'hBD: r = is_1047 ? 8'h5D : SUB_CHAR;
      8'hC0: r = 8'h7B;
      [8'hC1:8'hC9]: r = b - 8'h80;
      8'hD0: r = 8'h7D;
      [8'hD1:8'hD9]: r = b - 8'h87;
      8'hE0: r = 8'h5C;
      [8'hE2:8'hE9]: r = b - 8'h8F;
      [8'hF0:8'hF9]: r = b - 8'hC0;
      8'hFF: r = 8'hFF;
      default: r = SUB_CHAR;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/vrbd_front.sv */
`default_nettype none
module vrbd_front
  import vrbd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [BYTE_W-1:0] stream_byte,
  input  wire logic [LEN_W-1:0]  max_payload,
  output logic                   push,
  output item_t                  push_item
);

  phase_t             phase_r, phase_nxt;
  logic [BYTE_W-1:0]  len_hi_r, len_hi_nxt;
  logic [LEN_W-1:0]   blk_left_r, blk_left_nxt;
  logic [LEN_W-1:0]   rec_left_r, rec_left_nxt;
  logic [LEN_W-1:0]   blk_dec;
  logic [LEN_W-1:0]   rec_dec;
  logic [LEN_W-1:0]   blk_body;
  logic [LEN_W-1:0]   rec_body;
  logic               emit;

  // Where to go at a record boundary, given the payload still left.
  function automatic phase_t boundary(input logic [LEN_W-1:0] left);
    phase_t p;
    if (left >= DESC_LEN) begin
      p = PH_RDW0;
    end else if (left == '0) begin
      p = PH_BDW0;
    end else begin
      p = PH_SKIP;
    end
    return p;
  endfunction

  assign blk_dec  = blk_left_r - {{(LEN_W-1){1'b0}}, |blk_left_r};
  assign rec_dec  = rec_left_r - {{(LEN_W-1){1'b0}}, |rec_left_r};
  assign blk_body = blk_left_r - DESC_LEN;
  assign rec_body = rec_left_r - DESC_LEN;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_BDW0;
      len_hi_r   <= '0;
      blk_left_r <= '0;
      rec_left_r <= '0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      len_hi_r   <= len_hi_nxt;
      blk_left_r <= blk_left_nxt;
      rec_left_r <= rec_left_nxt;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    len_hi_nxt     = len_hi_r;
    blk_left_nxt   = blk_left_r;
    rec_left_nxt   = rec_left_r;
    emit           = 1'b0;
    push_item.kind = KIND_BYTE;
    push_item.data = '0;
    push_item.last = 1'b0;
    case (phase_r)
      PH_BDW0: begin
        len_hi_nxt = stream_byte;
        phase_nxt  = PH_BDW1;
      end
      PH_BDW1: begin
        blk_left_nxt = {len_hi_r, stream_byte};
        phase_nxt    = PH_BDW2;
      end
      PH_BDW2: begin
        phase_nxt = PH_BDW3;
      end
      PH_BDW3: begin
        if (blk_left_r < DESC_LEN || blk_body > max_payload) begin
          phase_nxt      = PH_DEAD;
          emit           = 1'b1;
          push_item.kind = KIND_BLOCK_BAD;
        end else begin
          blk_left_nxt = blk_body;
          phase_nxt    = boundary(blk_body);
        end
      end
      PH_SKIP: begin
        blk_left_nxt = blk_dec;
        if (blk_dec == '0) begin
          phase_nxt = PH_BDW0;
        end
      end
      PH_RDW0: begin
        len_hi_nxt   = stream_byte;
        blk_left_nxt = blk_dec;
        phase_nxt    = PH_RDW1;
      end
      PH_RDW1: begin
        rec_left_nxt = {len_hi_r, stream_byte};
        blk_left_nxt = blk_dec;
        phase_nxt    = PH_RDW2;
      end
      PH_RDW2: begin
        blk_left_nxt = blk_dec;
        phase_nxt    = PH_RDW3;
      end
      PH_RDW3: begin
        blk_left_nxt = blk_dec;
        if (rec_left_r < DESC_LEN || rec_body > blk_dec) begin
          phase_nxt      = PH_DEAD;
          emit           = 1'b1;
          push_item.kind = KIND_RECORD_BAD;
        end else begin
          rec_left_nxt = rec_body;
          if (rec_body == '0) begin
            phase_nxt      = boundary(blk_dec);
            emit           = 1'b1;
            push_item.kind = KIND_EMPTY;
            push_item.last = 1'b1;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        blk_left_nxt   = blk_dec;
        rec_left_nxt   = rec_dec;
        emit           = 1'b1;
        push_item.data = stream_byte;
        if (rec_dec == '0) begin
          push_item.last = 1'b1;
          phase_nxt      = boundary(blk_dec);
        end
      end
      PH_DEAD: begin
        phase_nxt = PH_DEAD;
      end
      default: begin
        phase_nxt = PH_DEAD;
      end
    endcase
  end

  assign push = accept & emit;

endmodule
`default_nettype wire

/* rtl/core/vrbd_queue.sv */
`default_nettype none
module vrbd_queue
  import vrbd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  input  wire logic  pop,
  output item_t      head_item,
  output queue_status_t status
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

  item_t             slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign status.full  = (count_r == FULL_CNT);
  assign status.empty = (count_r == '0);
  assign do_push      = push & ~status.full;
  assign do_pop       = pop & ~status.empty;
  assign head_item    = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/vrbd_back.sv */
`default_nettype none
module vrbd_back
  import vrbd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire queue_status_t     q_status,
  input  wire item_t             head_item,
  input  wire mode_t             mode,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [KIND_W-1:0]      out_kind,
  output logic [BYTE_W-1:0]      out_record_byte,
  output logic                   out_record_last
);

  logic              valid_r, valid_nxt;
  item_t             item_r;
  logic [BYTE_W-1:0] xlat;

  always_comb begin
    case (mode)
      MODE_037:  xlat = ebcdic_to_ascii(head_item.data, 1'b0);
      MODE_1047: xlat = ebcdic_to_ascii(head_item.data, 1'b1);
      default:   xlat = head_item.data;
    endcase
  end

  // Refill the output word whenever it is empty or being taken and the queue holds an item.
  assign pop = ~q_status.empty & (~valid_r | ~out_stall);

  always_comb begin
    valid_nxt = valid_r;
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item_r.kind <= head_item.kind;
      item_r.data <= (head_item.kind == KIND_BYTE) ? xlat : '0;
      item_r.last <= head_item.last;
    end
  end

  assign out_valid       = valid_r;
  assign out_kind        = item_r.kind;
  assign out_record_byte = item_r.data;
  assign out_record_last = item_r.last;

endmodule
`default_nettype wire

/* rtl/core/variable_record_block_deframer.sv */
`default_nettype none
// Variable-blocked record deframer. Takes one stream byte per clock while
// in_stall is low and sends out each record data byte as one word, translated
// to ASCII from EBCDIC code page 037 or 1047 when translate_mode asks for it,
// with record_last on the final byte; an empty record gives one kind 1 word.
// A bad block descriptor (length under 4 or payload over max_block_payload)
// gives kind 2, a bad record descriptor (length under 4 or past the block
// end) kind 3, and after either the block swallows all input until reset.
// Rate is one byte per clock while in_stall is low; the combinational parser
// feeds a two-word queue that lets it and the registered output stall on
// their own, and a result passes a queue slot and then the output register.
// Write the configuration registers only while no words are in flight.
module variable_record_block_deframer
  import vrbd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [BYTE_W-1:0]     in_stream_byte,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [KIND_W-1:0]          out_kind,
  output logic [BYTE_W-1:0]          out_record_byte,
  output logic                       out_record_last,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  mode_t            mode_r;
  logic [LEN_W-1:0] max_payload_r;
  logic             accept;
  logic             push;
  logic             pop;
  item_t            push_item;
  item_t            head_item;
  queue_status_t    q_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_NONE;
      max_payload_r <= MAX_PAYLOAD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRANSLATE_MODE:    mode_r        <= mode_t'(cfg_wdata[MODE_W-1:0]);
        REG_MAX_BLOCK_PAYLOAD: max_payload_r <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold input while the queue has no free slot.
  assign in_stall = q_status.full;
  assign accept   = in_valid & ~q_status.full;

  vrbd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .stream_byte (in_stream_byte),
    .max_payload (max_payload_r),
    .push        (push),
    .push_item   (push_item)
  );

  vrbd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .status    (q_status)
  );

  vrbd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_status        (q_status),
    .head_item       (head_item),
    .mode            (mode_r),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_record_byte (out_record_byte),
    .out_record_last (out_record_last)
  );

endmodule
`default_nettype wire
